// File: rtl/rlss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rlss_pkg;

	localparam int MAX_RUNS = 64;
	localparam int DATA_W   = 31;
	localparam int SLOT_W   = $clog2(MAX_RUNS);
	localparam int PTR_W    = $clog2(2 * MAX_RUNS);

	localparam logic [PTR_W:0] PTR_MOD = (PTR_W + 1)'(2 * MAX_RUNS);

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_SKIP   = 2'd2
	} command_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CMP,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [1:0]        command;
		logic [DATA_W-1:0] run_length;
		logic [DATA_W-1:0] run_value;
		logic [DATA_W-1:0] request_count;
	} in_t;

	typedef struct packed {
		logic              found;
		logic [DATA_W-1:0] element_value;
	} out_t;

	typedef struct packed {
		logic              wr_en;
		logic              wr_value_en;
		logic [SLOT_W-1:0] wr_slot;
		logic [DATA_W-1:0] wr_count;
		logic [DATA_W-1:0] wr_value;
		logic              rd_en;
		logic [SLOT_W-1:0] rd_slot;
	} store_req_t;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(2 * MAX_RUNS - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	function automatic logic [SLOT_W-1:0] ptr_slot(input logic [PTR_W-1:0] p);
		if ({1'b0, p} >= (PTR_W + 1)'(MAX_RUNS)) begin
			return SLOT_W'(p - PTR_W'(MAX_RUNS));
		end
		return SLOT_W'(p);
	endfunction

	function automatic logic [PTR_W-1:0] occupancy(input logic [PTR_W-1:0] t,
			input logic [PTR_W-1:0] h);
		logic [PTR_W:0] d;
		d = {1'b0, t} - {1'b0, h};
		if (d[PTR_W]) begin
			d = d + PTR_MOD;
		end
		return PTR_W'(d);
	endfunction

endpackage

`default_nettype wire

// File: rtl/rlss_run_store.sv
`timescale 1ns / 1ps
`default_nettype none

module rlss_run_store (
	input  wire                       clk,
	input  rlss_pkg::store_req_t      req,
	output logic [rlss_pkg::DATA_W-1:0] rd_count,
	output logic [rlss_pkg::DATA_W-1:0] rd_value
);
	import rlss_pkg::*;

	logic [DATA_W-1:0] count_mem [MAX_RUNS];
	logic [DATA_W-1:0] value_mem [MAX_RUNS];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			count_mem[req.wr_slot] <= req.wr_count;
		end
		if (req.rd_en) begin
			rd_count <= count_mem[req.rd_slot];
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en && req.wr_value_en) begin
			value_mem[req.wr_slot] <= req.wr_value;
		end
		if (req.rd_en) begin
			rd_value <= value_mem[req.rd_slot];
		end
	end

endmodule

`default_nettype wire

// File: rtl/run_length_sequence_skipper.sv
`timescale 1ns / 1ps
`default_nettype none

// Clear and append leave the sequencer idle; a new request is taken every cycle for them.
// Skip: the sequencer walks the stored runs from the head; each run read costs a store
// read state (ST_READ) then a subtract/compare state (ST_CMP), after which ST_OUT loads
// the output register. No request is taken until the result is handed to that register.
// Reset clears the head and tail pointers, the sequencer and the result valid flag; the run store is not
// cleared and holds no valid bits, since only written entries are ever read.
module run_length_sequence_skipper (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cmd_valid,
	output logic               cmd_stall,
	input  rlss_pkg::in_t      cmd_data,
	output logic               res_valid,
	input  wire                res_stall,
	output rlss_pkg::out_t     res_data
);
	import rlss_pkg::*;

	state_t            state_q, state_d;
	logic [PTR_W-1:0]  head_q, head_d;
	logic [PTR_W-1:0]  tail_q, tail_d;
	logic [DATA_W-1:0] n_q, n_d;
	logic              res_found_q, res_found_d;
	logic [DATA_W-1:0] res_value_q, res_value_d;
	logic              res_valid_q;
	out_t              res_data_q;
	logic              load_out;

	store_req_t        st_req;
	logic [DATA_W-1:0] rd_count;
	logic [DATA_W-1:0] rd_value;

	logic [PTR_W-1:0]  occ;
	logic [DATA_W:0]   sub;
	logic [DATA_W:0]   neg;
	logic              n_gt;

	rlss_run_store u_store (
		.clk      (clk),
		.req      (st_req),
		.rd_count (rd_count),
		.rd_value (rd_value)
	);

	assign occ  = occupancy(tail_q, head_q);
	// shared subtractor: request remainder minus stored run count
	assign sub  = {1'b0, n_q} - {1'b0, rd_count};
	assign neg  = (DATA_W + 1)'(0) - sub;
	assign n_gt = !sub[DATA_W] && (sub[DATA_W-1:0] != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		tail_d      = tail_q;
		n_d         = n_q;
		res_found_d = res_found_q;
		res_value_d = res_value_q;
		st_req      = '0;
		load_out    = 1'b0;
		cmd_stall   = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					case (cmd_data.command)
						CMD_CLEAR: begin
							head_d = '0;
							tail_d = '0;
						end
						CMD_APPEND: begin
							if (occ < PTR_W'(MAX_RUNS)) begin
								st_req.wr_en       = 1'b1;
								st_req.wr_value_en = 1'b1;
								st_req.wr_slot     = ptr_slot(tail_q);
								st_req.wr_count    = cmd_data.run_length;
								st_req.wr_value    = cmd_data.run_value;
								tail_d             = ptr_next(tail_q);
							end
						end
						CMD_SKIP: begin
							n_d         = cmd_data.request_count;
							res_found_d = 1'b0;
							res_value_d = '0;
							state_d     = ST_READ;
						end
						default: begin
						end
					endcase
				end
			end
			ST_READ: begin
				if (n_q == '0 || occ == '0) begin
					state_d = ST_OUT;
				end else begin
					st_req.rd_en   = 1'b1;
					st_req.rd_slot = ptr_slot(head_q);
					state_d        = ST_CMP;
				end
			end
			ST_CMP: begin
				if (n_gt) begin
					if (occ == PTR_W'(1)) begin
						// sequence runs out: drop everything
						head_d  = tail_q;
						state_d = ST_OUT;
					end else begin
						n_d     = sub[DATA_W-1:0];
						head_d  = ptr_next(head_q);
						state_d = ST_READ;
					end
				end else begin
					st_req.wr_en    = 1'b1;
					st_req.wr_slot  = ptr_slot(head_q);
					st_req.wr_count = neg[DATA_W-1:0];
					res_found_d     = 1'b1;
					res_value_d     = rd_value;
					state_d         = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!res_valid_q || !res_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			head_q <= head_d;
			tail_q <= tail_d;
			if (load_out) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		n_q         <= n_d;
		res_found_q <= res_found_d;
		res_value_q <= res_value_d;
		if (load_out) begin
			res_data_q.found         <= res_found_q;
			res_data_q.element_value <= res_value_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_data_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ <= PTR_W'(MAX_RUNS))
		else $error("run queue occupancy exceeds capacity");

	a_rise_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result raised outside the output state");

	a_short_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall && cmd_data.command != CMD_SKIP) |=> state_q == ST_IDLE)
		else $error("clear or append left the sequencer busy");

	a_cmp_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CMP |-> (n_q != '0 && occ != '0))
		else $error("compare step entered with nothing to consume");

endmodule

`default_nettype wire

// File: tb/run_length_sequence_skipper_test.sv
`timescale 1ns / 1ps

module run_length_sequence_skipper_test;
	import rlss_pkg::*;

	localparam logic [1:0]  CMD_UNUSED     = 2'd3;
	localparam int          WATCHDOG_LIMIT = 4000;
	localparam int          RANDOM_ITEMS   = 1350;
	localparam int          QUIET_ITEMS    = 300;
	localparam longint      DATA_MAX       = 64'h7FFF_FFFF;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	in_t  cmd_data;
	logic res_valid;
	logic res_stall;
	out_t res_data;

	// shadow of the pair store and its pointers
	logic [DATA_W-1:0] run_count_model [MAX_RUNS];
	logic [DATA_W-1:0] run_value_model [MAX_RUNS];
	logic [PTR_W-1:0]  head_model;
	logic [PTR_W-1:0]  tail_model;

	out_t pending_elements [$];
	out_t oldest_element;

	int error_count;
	int requests_sent;
	int quiet_cycles;
	int rx_gap;
	int send_idle_pct;
	int recv_idle_pct;

	run_length_sequence_skipper DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_data  (cmd_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int runs_held();
		return (int'(tail_model) + 2 * MAX_RUNS - int'(head_model)) % (2 * MAX_RUNS);
	endfunction

	function automatic int head_slot();
		return int'(head_model) % MAX_RUNS;
	endfunction

	function automatic longint elements_left();
		longint sum;
		sum = 0;
		for (int i = 0; i < runs_held(); i++) begin
			sum += run_count_model[(int'(head_model) + i) % MAX_RUNS];
		end
		return sum;
	endfunction

	function automatic logic [DATA_W-1:0] rand_field();
		return DATA_W'($urandom());
	endfunction

	function automatic logic [DATA_W-1:0] pick_run_length();
		case ($urandom_range(0, 19))
			0, 1: begin
				return '0;
			end
			2: begin
				return rand_field();
			end
			default: begin
				return DATA_W'($urandom_range(1, 5));
			end
		endcase
	endfunction

	// aim skips at run boundaries and at the end of the sequence
	function automatic logic [DATA_W-1:0] pick_request_count();
		longint left;
		left = elements_left();
		case ($urandom_range(0, 9))
			0: begin
				return '0;
			end
			1: begin
				return rand_field();
			end
			2: begin
				return (left <= DATA_MAX) ? DATA_W'(left) : rand_field();
			end
			3: begin
				return (left < DATA_MAX) ? DATA_W'(left + 1) : rand_field();
			end
			4: begin
				return (runs_held() != 0) ? run_count_model[head_slot()] : DATA_W'(1);
			end
			default: begin
				return DATA_W'($urandom_range(1, 12));
			end
		endcase
	endfunction

	task automatic apply_run_command(input in_t req);
		out_t              res;
		logic [DATA_W-1:0] left;
		int                slot;
		bit                done;
		case (req.command)
			CMD_CLEAR: begin
				head_model = '0;
				tail_model = '0;
			end
			CMD_APPEND: begin
				if (runs_held() < MAX_RUNS) begin
					slot = int'(tail_model) % MAX_RUNS;
					run_count_model[slot] = req.run_length;
					run_value_model[slot] = req.run_value;
					tail_model = PTR_W'((int'(tail_model) + 1) % (2 * MAX_RUNS));
				end
			end
			CMD_SKIP: begin
				res = '0;
				left = req.request_count;
				done = 1'b0;
				while (!done && left != 0 && runs_held() != 0) begin
					slot = head_slot();
					if (left > run_count_model[slot]) begin
						if (runs_held() == 1) begin
							// sequence exhausted: drop everything
							head_model = tail_model;
							done = 1'b1;
						end else begin
							left -= run_count_model[slot];
							head_model = PTR_W'((int'(head_model) + 1) % (2 * MAX_RUNS));
						end
					end else begin
						run_count_model[slot] -= left;
						res.found = 1'b1;
						res.element_value = run_value_model[slot];
						done = 1'b1;
					end
				end
				pending_elements.push_back(res);
			end
			default: begin
			end
		endcase
	endtask

	task automatic send_request(input in_t req);
		cmd_valid <= 1'b1;
		cmd_data <= req;
		do @(posedge clk); while (cmd_stall);
		apply_run_command(req);
		if (req.command != CMD_UNUSED) begin
			requests_sent++;
		end
		if ($urandom_range(1, 100) <= send_idle_pct) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	task automatic wait_for_results();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (pending_elements.size() != 0);
	endtask

	task automatic send_skip(input logic [DATA_W-1:0] count);
		send_request(in_t'{CMD_SKIP, rand_field(), rand_field(), count});
	endtask

	task automatic send_append(input logic [DATA_W-1:0] length, input logic [DATA_W-1:0] value);
		send_request(in_t'{CMD_APPEND, length, value, rand_field()});
	endtask

	task automatic test_empty_table();
		send_skip(DATA_W'(5));
		send_skip('0);
		send_skip(DATA_W'(DATA_MAX));
	endtask

	task automatic test_run_walk();
		send_append(DATA_W'(3), DATA_W'(DATA_MAX));
		send_append('0, '0);
		send_append(DATA_W'(DATA_MAX), DATA_W'(31'h2AAA_AAAA));
		send_append(DATA_W'(5), DATA_W'(31'h5555_5555));
		// end exactly on the first run, then pass over zero-count runs
		send_skip(DATA_W'(3));
		send_skip('0);
		send_request(in_t'{CMD_UNUSED, rand_field(), rand_field(), rand_field()});
		send_skip(DATA_W'(1));
		send_skip(DATA_W'(DATA_MAX));
		send_skip(DATA_W'(5));
		send_skip(DATA_W'(1));
	endtask

	task automatic test_clear();
		send_append(DATA_W'(4), rand_field());
		send_append(DATA_W'(2), rand_field());
		send_request(in_t'{CMD_CLEAR, rand_field(), rand_field(), rand_field()});
		send_skip(DATA_W'(1));
		send_append(DATA_W'(1), rand_field());
		send_skip(DATA_W'(1));
	endtask

	task automatic test_full_table();
		send_request(in_t'{CMD_CLEAR, rand_field(), rand_field(), rand_field()});
		// one pair beyond capacity must be dropped
		for (int i = 0; i <= MAX_RUNS; i++) begin
			send_append(DATA_W'(1), rand_field());
		end
		send_skip(DATA_W'(MAX_RUNS));
		send_skip(DATA_W'(1));
		send_append(DATA_W'(2), rand_field());
		send_skip(DATA_W'(1));
		wait_for_results();
		for (int i = 0; i < MAX_RUNS; i++) begin
			send_append(DATA_W'($urandom_range(1, 3)), rand_field());
		end
		send_skip(DATA_W'(DATA_MAX));
		wait_for_results();
	endtask

	task automatic test_random_runs();
		int start;
		int pick;
		int batch;
		start = requests_sent;
		while (requests_sent - start < RANDOM_ITEMS) begin
			if (requests_sent - start > RANDOM_ITEMS - QUIET_ITEMS) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else begin
				send_idle_pct = $urandom_range(0, 3) * 15;
				recv_idle_pct = $urandom_range(0, 3) * 15;
			end
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				send_request(in_t'{CMD_CLEAR, rand_field(), rand_field(), rand_field()});
			end else if (pick < 10) begin
				send_request(in_t'{CMD_UNUSED, rand_field(), rand_field(), rand_field()});
			end
			if ($urandom_range(0, 9) < 7) begin
				batch = $urandom_range(1, 6);
			end else if ($urandom_range(0, 9) < 8) begin
				batch = $urandom_range(7, 30);
			end else begin
				batch = $urandom_range(55, 70);
			end
			repeat (batch) send_append(pick_run_length(), rand_field());
			repeat ($urandom_range(1, 6)) send_skip(pick_request_count());
			if (pick >= 96 && requests_sent - start <= RANDOM_ITEMS - QUIET_ITEMS) begin
				wait_for_results();
			end
		end
	endtask

	initial begin
		res_stall = 1'b0;
		rx_gap = 0;
		forever begin
			@(posedge clk);
			if (rx_gap > 0) begin
				rx_gap--;
				res_stall <= 1'b1;
			end else if ($urandom_range(1, 100) <= recv_idle_pct) begin
				rx_gap = $urandom_range(0, 8);
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (pending_elements.size() == 0) begin
				$error("unexpected result: found %0b element_value %0h",
					res_data.found, res_data.element_value);
				error_count++;
			end else begin
				oldest_element = pending_elements.pop_front();
				if (res_data.found !== oldest_element.found) begin
					$error("found: expected %0b, actual %0b",
						oldest_element.found, res_data.found);
					error_count++;
				end
				if (res_data.element_value !== oldest_element.element_value) begin
					$error("element_value: expected %0h, actual %0h",
						oldest_element.element_value, res_data.element_value);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd_data = '0;
		head_model = '0;
		tail_model = '0;
		error_count = 0;
		requests_sent = 0;
		quiet_cycles = 0;
		send_idle_pct = 20;
		recv_idle_pct = 20;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_table();
		test_run_walk();
		test_clear();
		test_full_table();
		test_random_runs();
		wait_for_results();
		repeat (200) @(posedge clk);
		if (error_count == 0 && pending_elements.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/rlss_pkg.sv
rtl/rlss_run_store.sv
rtl/run_length_sequence_skipper.sv
tb/run_length_sequence_skipper_test.sv
